FILE: rtl/grt_pkg.sv
`timescale 1ns / 1ps

package grt_pkg;

   // Field widths of the request and response channels
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int CELL_W    = 8;
   localparam int COUNT_W   = 13;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   // Default grid size
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // Width of the visited epoch mark
   localparam int EPOCH_W = 4;

   localparam logic [CFG_W-1:0]     CFG_RESET = 7'd64;
   localparam logic [COUNT_W-1:0]   COUNT_MAX = 13'd8191;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   // Request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN   = 1'b1;

   // Map characters
   localparam logic [CELL_W-1:0] CHAR_TARGET_C = 8'h43;
   localparam logic [CELL_W-1:0] CHAR_TARGET_E = 8'h45;
   localparam logic [CELL_W-1:0] CHAR_WALL     = 8'h31;
   localparam logic [CELL_W-1:0] CHAR_KEEPER   = 8'h4B;
   localparam logic [CELL_W-1:0] CHAR_EMPTY    = 8'h00;

   typedef logic [EPOCH_W-1:0] epoch_type;

   typedef struct packed {
      logic              cmd;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] cell_req;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_CHECK,
      ST_TEST,
      ST_POP,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      DIR_START,
      DIR_DOWN,
      DIR_UP,
      DIR_RIGHT,
      DIR_LEFT
   } dir_type;

   function automatic logic is_blocking(input logic [CELL_W-1:0] ch);
      return (ch == CHAR_WALL) || (ch == CHAR_KEEPER) || (ch == CHAR_EMPTY);
   endfunction

   function automatic logic is_target(input logic [CELL_W-1:0] ch);
      return (ch == CHAR_TARGET_C) || (ch == CHAR_TARGET_E);
   endfunction

endpackage

FILE: rtl/grt_if.sv
`timescale 1ns / 1ps

interface grt_req_if;
   import grt_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [CELL_W-1:0] cell_req;

   modport source (output valid, output cmd, output row, output col, output cell_req,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input cell_req,
                   output ready);
endinterface

interface grt_rsp_if;
   import grt_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] target_count;

   modport source (output valid, output target_count, input ready);
   modport sink   (input valid, input target_count, output ready);
endinterface

interface grt_csr_if;
   import grt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/grt_ram.sv
`timescale 1ns / 1ps

module grt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/grt_nbr.sv
`timescale 1ns / 1ps

module grt_nbr #(
   parameter int MAX_ROWS = grt_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = grt_pkg::MAX_COLS_DEF,
   parameter int CMP_W    = 9
) (
   input  grt_pkg::dir_type                          dir,
   input  logic [grt_pkg::ROW_W-1:0]                 start_r,
   input  logic [grt_pkg::COL_W-1:0]                 start_c,
   input  logic [$clog2(MAX_ROWS)-1:0]               base_r,
   input  logic [$clog2(MAX_COLS)-1:0]               base_c,
   input  logic [CMP_W-1:0]                          lim_r,
   input  logic [CMP_W-1:0]                          lim_c,
   output logic                                      cand_ok,
   output logic [$clog2(MAX_ROWS)-1:0]               cand_r,
   output logic [$clog2(MAX_COLS)-1:0]               cand_c,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]      cand_addr
);
   import grt_pkg::*;

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

   logic [CMP_W-1:0] r_ext;
   logic [CMP_W-1:0] c_ext;
   logic             step_ok;

   // Form the candidate cell for the current direction and check its bounds
   always_comb begin
      r_ext   = CMP_W'(base_r);
      c_ext   = CMP_W'(base_c);
      step_ok = 1'b1;
      case (dir)
         DIR_START: begin
            r_ext = CMP_W'(start_r);
            c_ext = CMP_W'(start_c);
         end
         DIR_DOWN: begin
            r_ext = CMP_W'(base_r) + CMP_W'(1);
         end
         DIR_UP: begin
            step_ok = (base_r != '0);
            r_ext   = CMP_W'(base_r) - CMP_W'(1);
         end
         DIR_RIGHT: begin
            c_ext = CMP_W'(base_c) + CMP_W'(1);
         end
         DIR_LEFT: begin
            step_ok = (base_c != '0);
            c_ext   = CMP_W'(base_c) - CMP_W'(1);
         end
         default: begin
            step_ok = 1'b0;
         end
      endcase
   end

   assign cand_ok   = step_ok && (r_ext < lim_r) && (c_ext < lim_c);
   assign cand_r    = r_ext[RW-1:0];
   assign cand_c    = c_ext[CW-1:0];
   assign cand_addr = AW'(cand_r) * AW'(MAX_COLS) + AW'(cand_c);

endmodule

FILE: rtl/grt_ctrl.sv
`timescale 1ns / 1ps

module grt_ctrl #(
   parameter int MAX_ROWS = grt_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = grt_pkg::MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [grt_pkg::CFG_W-1:0]     rows_cfg,
   input  logic [grt_pkg::CFG_W-1:0]     cols_cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  grt_pkg::req_type              req,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [grt_pkg::COUNT_W-1:0]   rsp_count
);
   import grt_pkg::*;

   localparam int RW      = $clog2(MAX_ROWS);
   localparam int CW      = $clog2(MAX_COLS);
   localparam int CELLS   = MAX_ROWS * MAX_COLS;
   localparam int AW      = $clog2(CELLS);
   localparam int DW      = $clog2(CELLS + 1);
   localparam int SW      = 1 + RW + CW;
   localparam int DIM_A   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DIM_MAX = (DIM_A > 127) ? DIM_A : 127;
   localparam int CMP_W   = $clog2(DIM_MAX + 2);

   localparam epoch_type EPOCH_LAST = {EPOCH_W{1'b1}};

   state_type          state_ff, state_in;
   dir_type            dir_ff, dir_in;
   logic [ROW_W-1:0]   start_r_ff, start_r_in;
   logic [COL_W-1:0]   start_c_ff, start_c_in;
   logic [RW-1:0]      base_r_ff, base_r_in;
   logic [CW-1:0]      base_c_ff, base_c_in;
   logic [CMP_W-1:0]   lim_r_ff, lim_r_in;
   logic [CMP_W-1:0]   lim_c_ff, lim_c_in;
   logic [RW-1:0]      cand_r_ff, cand_r_in;
   logic [CW-1:0]      cand_c_ff, cand_c_in;
   logic [AW-1:0]      cand_addr_ff, cand_addr_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   epoch_type          epoch_ff, epoch_in;
   logic               need_clear_ff, need_clear_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Neighbor unit outputs
   logic               cand_ok;
   logic [RW-1:0]      cand_r;
   logic [CW-1:0]      cand_c;
   logic [AW-1:0]      cand_addr;

   // Memory ports
   logic               grid_wr_en, grid_rd_en;
   logic [AW-1:0]      grid_wr_addr;
   logic [CELL_W-1:0]  grid_rd_data;
   logic               vis_wr_en, vis_rd_en;
   logic [AW-1:0]      vis_wr_addr;
   epoch_type          vis_wr_data, vis_rd_data;
   logic               stk_wr_en, stk_rd_en;
   logic [AW-1:0]      stk_rd_addr;
   logic [SW-1:0]      stk_wr_data, stk_rd_data;

   logic               dir_last;
   dir_type            dir_next;
   logic               wr_in_grid;

   grt_nbr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .CMP_W    (CMP_W)
   ) u_nbr (
      .dir       (dir_ff),
      .start_r   (start_r_ff),
      .start_c   (start_c_ff),
      .base_r    (base_r_ff),
      .base_c    (base_c_ff),
      .lim_r     (lim_r_ff),
      .lim_c     (lim_c_ff),
      .cand_ok   (cand_ok),
      .cand_r    (cand_r),
      .cand_c    (cand_c),
      .cand_addr (cand_addr)
   );

   grt_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (req.cell_req),
      .rd_en   (grid_rd_en),
      .rd_addr (cand_addr),
      .rd_data (grid_rd_data)
   );

   grt_ram #(.WIDTH(EPOCH_W), .DEPTH(CELLS)) u_vis_ram (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_en   (vis_rd_en),
      .rd_addr (cand_addr),
      .rd_data (vis_rd_data)
   );

   grt_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   // Direction order: down, up, right, left
   always_comb begin
      dir_last = 1'b0;
      dir_next = DIR_DOWN;
      case (dir_ff)
         DIR_START: dir_last = 1'b1;
         DIR_DOWN:  dir_next = DIR_UP;
         DIR_UP:    dir_next = DIR_RIGHT;
         DIR_RIGHT: dir_next = DIR_LEFT;
         DIR_LEFT:  dir_last = 1'b1;
         default:   dir_last = 1'b1;
      endcase
   end

   assign wr_in_grid   = (CMP_W'(req.row) < CMP_W'(MAX_ROWS)) &&
                         (CMP_W'(req.col) < CMP_W'(MAX_COLS));
   assign grid_wr_addr = AW'(req.row) * AW'(MAX_COLS) + AW'(req.col);
   assign stk_wr_data  = {is_target(grid_rd_data), cand_r_ff, cand_c_ff};
   assign stk_rd_addr  = AW'(depth_ff - DW'(1));

   // Sequence the fill: probe each neighbor, push passable cells, pop
   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      start_r_in    = start_r_ff;
      start_c_in    = start_c_ff;
      base_r_in     = base_r_ff;
      base_c_in     = base_c_ff;
      lim_r_in      = lim_r_ff;
      lim_c_in      = lim_c_ff;
      cand_r_in     = cand_r_ff;
      cand_c_in     = cand_c_ff;
      cand_addr_in  = cand_addr_ff;
      depth_in      = depth_ff;
      count_in      = count_ff;
      epoch_in      = epoch_ff;
      need_clear_in = need_clear_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      req_ready     = 1'b0;
      grid_wr_en    = 1'b0;
      grid_rd_en    = 1'b0;
      vis_wr_en     = 1'b0;
      vis_rd_en     = 1'b0;
      vis_wr_addr   = cand_addr_ff;
      vis_wr_data   = epoch_ff;
      stk_wr_en     = 1'b0;
      stk_rd_en     = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req.cmd == CMD_WRITE) begin
                  grid_wr_en = wr_in_grid;
               end else begin
                  start_r_in = req.row;
                  start_c_in = req.col;
                  lim_r_in   = (CMP_W'(rows_cfg) > CMP_W'(MAX_ROWS)) ?
                               CMP_W'(MAX_ROWS) : CMP_W'(rows_cfg);
                  lim_c_in   = (CMP_W'(cols_cfg) > CMP_W'(MAX_COLS)) ?
                               CMP_W'(MAX_COLS) : CMP_W'(cols_cfg);
                  count_in   = '0;
                  depth_in   = '0;
                  dir_in     = DIR_START;
                  if (need_clear_ff || (epoch_ff == EPOCH_LAST)) begin
                     epoch_in      = epoch_type'(1);
                     need_clear_in = 1'b0;
                     clr_in        = '0;
                     state_in      = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + epoch_type'(1);
                     state_in = ST_CHECK;
                  end
               end
            end
         end

         ST_CLEAR: begin
            vis_wr_en   = 1'b1;
            vis_wr_addr = clr_ff;
            vis_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (cand_ok) begin
               grid_rd_en   = 1'b1;
               vis_rd_en    = 1'b1;
               cand_r_in    = cand_r;
               cand_c_in    = cand_c;
               cand_addr_in = cand_addr;
               state_in     = ST_TEST;
            end else if (dir_last) begin
               state_in = ST_POP;
            end else begin
               dir_in = dir_next;
            end
         end

         ST_TEST: begin
            // Mark and push a fresh passable cell
            if ((vis_rd_data != epoch_ff) && !is_blocking(grid_rd_data)) begin
               vis_wr_en = 1'b1;
               if (depth_ff < DW'(CELLS)) begin
                  stk_wr_en = 1'b1;
                  depth_in  = depth_ff + DW'(1);
               end
            end
            if (dir_last) begin
               state_in = ST_POP;
            end else begin
               dir_in   = dir_next;
               state_in = ST_CHECK;
            end
         end

         ST_POP: begin
            if (depth_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               stk_rd_en = 1'b1;
               depth_in  = depth_ff - DW'(1);
               state_in  = ST_LOAD;
            end
         end

         ST_LOAD: begin
            base_r_in = stk_rd_data[RW+CW-1:CW];
            base_c_in = stk_rd_data[CW-1:0];
            if (stk_rd_data[SW-1] && (count_ff < COUNT_MAX)) begin
               count_in = count_ff + COUNT_W'(1);
            end
            dir_in   = DIR_DOWN;
            state_in = ST_CHECK;
         end

         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dir_ff        <= DIR_START;
         depth_ff      <= '0;
         count_ff      <= '0;
         epoch_ff      <= '0;
         need_clear_ff <= 1'b1;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dir_ff        <= dir_in;
         depth_ff      <= depth_in;
         count_ff      <= count_in;
         epoch_ff      <= epoch_in;
         need_clear_ff <= need_clear_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      start_r_ff   <= start_r_in;
      start_c_ff   <= start_c_in;
      base_r_ff    <= base_r_in;
      base_c_ff    <= base_c_in;
      lim_r_ff     <= lim_r_in;
      lim_c_ff     <= lim_c_in;
      cand_r_ff    <= cand_r_in;
      cand_c_ff    <= cand_c_in;
      cand_addr_ff <= cand_addr_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule

FILE: rtl/grid_reachable_target_counter.sv
// Grid write request: accepted while idle, no response.
// Run request: an accept and a start-cell probe, then per reached cell a pop, a load and a
// probe of each neighbor (a read and a test for an in-bounds one), then a pop of the empty
// stack and the posting of the count, held while an earlier response still waits.
// The visited map keeps an epoch mark; a pass clearing all MAX_ROWS*MAX_COLS cells runs at the
// first run after reset and whenever the epoch wraps (every fifteenth run). One run at a time.
// Synchronous active-high reset: idle, empty stack, registers at 64; grid contents undefined.
`timescale 1ns / 1ps

module grid_reachable_target_counter #(
   parameter int MAX_ROWS = grt_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = grt_pkg::MAX_COLS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   grt_req_if.sink   req_chan,
   grt_rsp_if.source rsp_chan,
   grt_csr_if.sink   csr_chan
);
   import grt_pkg::*;

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   req_type          req;

   // Take register writes at any time
   assign csr_chan.ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_ROWS) begin
            rows_in = csr_chan.data;
         end else if (csr_chan.index == CSR_COLS) begin
            cols_in = csr_chan.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Pack the request fields
   assign req.cmd      = req_chan.cmd;
   assign req.row      = req_chan.row;
   assign req.col      = req_chan.col;
   assign req.cell_req = req_chan.cell_req;

   grt_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .rows_cfg  (rows_ff),
      .cols_cfg  (cols_ff),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req       (req),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_count (rsp_chan.target_count)
   );

endmodule

FILE: bench/tb_grid_reachable_target_counter.sv
`timescale 1ns / 1ps

module tb_grid_reachable_target_counter;
   import grt_pkg::*;

   localparam int GRID_ROWS     = MAX_ROWS_DEF;
   localparam int GRID_COLS     = MAX_COLS_DEF;
   localparam int GRID_CELLS    = GRID_ROWS * GRID_COLS;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 1500;
   localparam int RANDOM_ITEMS  = 900;
   localparam int REPORT_MAX    = 10;

   // Passable map characters with no special meaning
   localparam logic [CELL_W-1:0] CHAR_FLOOR  = 8'h30;
   localparam logic [CELL_W-1:0] CHAR_PLAYER = 8'h50;

   // Register indexes past the end of the register list
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock;
   logic reset;

   grt_req_if req_bus();
   grt_rsp_if rsp_bus();
   grt_csr_if csr_bus();

   grid_reachable_target_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the grid and the fill bookkeeping
   logic [CELL_W-1:0]  grid_copy [GRID_CELLS];
   bit                 seen_map  [GRID_CELLS];
   int                 fill_stack[$];
   logic [CFG_W-1:0]   rows_cfg;
   logic [CFG_W-1:0]   cols_cfg;
   logic [COUNT_W-1:0] target_counts_due[$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_tag       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int count_errors   = 0;
   int fills_checked  = 0;
   int fills_sent     = 0;
   int writes_sent    = 0;
   int settings_used  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit of %0d reached with %0d counts outstanding",
                  CYCLE_LIMIT, target_counts_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit stops_walk(input logic [CELL_W-1:0] ch);
      return (ch == CHAR_WALL) || (ch == CHAR_KEEPER) || (ch == CHAR_EMPTY);
   endfunction

   // Mark a cell reached and queue it if it is in the area, fresh and passable
   function automatic void mark_and_push(input int r, input int c, input int nr, input int nc);
      int idx;
      if (r < 0 || c < 0 || r >= nr || c >= nc) return;
      idx = r * GRID_COLS + c;
      if (seen_map[idx] || stops_walk(grid_copy[idx])) return;
      seen_map[idx] = 1'b1;
      fill_stack.push_back(idx);
   endfunction

   function automatic logic [COUNT_W-1:0] count_reachable_targets(
      input logic [ROW_W-1:0] r0, input logic [COL_W-1:0] c0);
      int                 nr;
      int                 nc;
      int                 idx;
      int                 r;
      int                 c;
      logic [COUNT_W-1:0] total;
      nr = (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
      nc = (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
      total = '0;
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      fill_stack.delete();
      mark_and_push(int'(r0), int'(c0), nr, nc);
      while (fill_stack.size() > 0) begin
         idx = fill_stack.pop_back();
         r = idx / GRID_COLS;
         c = idx % GRID_COLS;
         if ((grid_copy[idx] == CHAR_TARGET_C || grid_copy[idx] == CHAR_TARGET_E) &&
             total != COUNT_MAX) begin
            total++;
         end
         mark_and_push(r + 1, c, nr, nc);
         mark_and_push(r - 1, c, nr, nc);
         mark_and_push(r, c + 1, nr, nc);
         mark_and_push(r, c - 1, nr, nc);
      end
      return total;
   endfunction

   function automatic logic [CELL_W-1:0] pick_cell_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return CHAR_WALL;
      else if (roll < 42) return CHAR_TARGET_C;
      else if (roll < 54) return CHAR_TARGET_E;
      else if (roll < 58) return CHAR_KEEPER;
      else if (roll < 62) return CHAR_EMPTY;
      else if (roll < 82) return CHAR_FLOOR;
      else if (roll < 88) return CHAR_PLAYER;
      return 8'($urandom);
   endfunction

   // Drive ready for results: long hold when asked, else random idling
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         hold_left <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted count with the oldest one due
   always @(posedge clock) begin : check_counts
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (target_counts_due.size() == 0) begin
            count_errors++;
            if (count_errors <= REPORT_MAX)
               $display("unexpected target count %0d with no fill outstanding",
                        rsp_bus.target_count);
         end else begin
            want = target_counts_due.pop_front();
            fills_checked++;
            if (rsp_bus.target_count !== want) begin
               count_errors++;
               if (count_errors <= REPORT_MAX)
                  $display("target count mismatch: expected %0d, got %0d",
                           want, rsp_bus.target_count);
            end
         end
      end
   end

   // Offer a request until taken, then update the shadow grid or counts due
   task automatic issue_request(input logic cmd, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col,
                                input logic [CELL_W-1:0] cell_byte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.row      <= row;
      req_bus.col      <= col;
      req_bus.cell_req <= cell_byte;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd == CMD_WRITE) begin
         grid_copy[int'(row) * GRID_COLS + int'(col)] = cell_byte;
         writes_sent++;
      end else begin
         target_counts_due.push_back(count_reachable_targets(row, col));
         fills_sent++;
      end
   endtask

   // Stop sending, wait for every count, then let trailing writes retire
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      while (target_counts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CFG_W-1:0] value);
      drain_and_settle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (index == CSR_ROWS) rows_cfg = value;
      else if (index == CSR_COLS) cols_cfg = value;
   endtask

   task automatic set_area(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      write_register(CSR_ROWS, rows);
      write_register(CSR_COLS, cols);
      settings_used++;
   endtask

   // Fill the whole grid so no run can probe an unwritten cell
   task automatic test_grid_load();
      send_idle_pct = 28;
      recv_idle_pct = 71;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            issue_request(CMD_WRITE, ROW_W'(r), COL_W'(c), pick_cell_byte());
         end
      end
   endtask

   task automatic test_directed_cases();
      set_area(7'd4, 7'd4);
      issue_request(CMD_WRITE, 6'd0, 6'd0, CHAR_TARGET_C);
      issue_request(CMD_WRITE, 6'd0, 6'd1, CHAR_TARGET_E);
      issue_request(CMD_WRITE, 6'd1, 6'd0, CHAR_FLOOR);
      issue_request(CMD_WRITE, 6'd1, 6'd1, CHAR_WALL);
      issue_request(CMD_WRITE, 6'd3, 6'd3, CHAR_KEEPER);
      issue_request(CMD_WRITE, 6'd2, 6'd3, CHAR_EMPTY);
      // stored even though it lies past the columns in use
      issue_request(CMD_WRITE, 6'd0, 6'd4, CHAR_TARGET_E);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'hFF);
      // blocked starts and starts outside the area
      issue_request(CMD_RUN, 6'd3, 6'd3, 8'h00);
      issue_request(CMD_RUN, 6'd2, 6'd3, 8'h00);
      issue_request(CMD_RUN, 6'd1, 6'd1, 8'h00);
      issue_request(CMD_RUN, 6'd4, 6'd0, 8'h00);
      issue_request(CMD_RUN, 6'd0, 6'd4, 8'h00);
      // widen the area to expose the cell stored outside it
      set_area(7'd4, 7'd5);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'h00);
      // empty area in each dimension
      write_register(CSR_ROWS, 7'd0);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'h00);
      set_area(7'd5, 7'd0);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'h00);
      // writes past the register list leave the area alone
      set_area(7'd2, 7'd2);
      write_register(CSR_SPARE_A, 7'h7F);
      write_register(CSR_SPARE_B, 7'h55);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'h00);
      // oversized registers saturate to the full grid
      set_area(7'd127, 7'd127);
      issue_request(CMD_WRITE, 6'd63, 6'd63, CHAR_TARGET_C);
      issue_request(CMD_WRITE, 6'd62, 6'd63, CHAR_FLOOR);
      issue_request(CMD_WRITE, 6'd63, 6'd62, 8'hFF);
      issue_request(CMD_RUN, 6'd63, 6'd63, 8'h00);
      set_area(7'd64, 7'd64);
      issue_request(CMD_RUN, 6'd0, 6'd0, 8'h00);
   endtask

   // Hold off results so the block backs up, then pause until all counts return
   task automatic test_result_stall();
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_area(7'd8, 7'd8);
      hold_tag++;
      for (int i = 0; i < 48; i++) begin
         r = ROW_W'($urandom_range(7));
         c = COL_W'($urandom_range(7));
         if (i == 36) drain_and_settle();
         if (i % 3 == 2) issue_request(CMD_RUN, r, c, 8'($urandom));
         else issue_request(CMD_WRITE, r, c, pick_cell_byte());
      end
   endtask

   // Phases of mixed writes and fills over random areas, mostly small
   task automatic test_random_traffic();
      int               sent;
      int               roll;
      int               items;
      int               max_fills;
      int               fills;
      int               nr;
      int               nc;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ((sent * 3) / RANDOM_ITEMS)
            0: begin
               send_idle_pct = 28;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         roll = $urandom_range(99);
         if (roll < 8) begin
            rows = CFG_W'($urandom_range(127, 33));
            cols = CFG_W'($urandom_range(127, 33));
            items = 8;
            max_fills = 2;
         end else if (roll < 20) begin
            rows = CFG_W'($urandom_range(24, 11));
            cols = CFG_W'($urandom_range(24, 11));
            items = 24;
            max_fills = 6;
         end else begin
            rows = CFG_W'($urandom_range(10, 1));
            cols = CFG_W'($urandom_range(10, 1));
            items = $urandom_range(40, 20);
            max_fills = items;
         end
         set_area(rows, cols);
         nr = (rows > GRID_ROWS) ? GRID_ROWS : int'(rows);
         nc = (cols > GRID_COLS) ? GRID_COLS : int'(cols);
         fills = 0;
         for (int i = 0; i < items; i++) begin
            if ($urandom_range(99) < 88) begin
               r = ROW_W'($urandom_range(nr - 1, 0));
               c = COL_W'($urandom_range(nc - 1, 0));
            end else begin
               r = ROW_W'($urandom);
               c = COL_W'($urandom);
            end
            if ($urandom_range(99) < 70 || fills >= max_fills) begin
               issue_request(CMD_WRITE, r, c, pick_cell_byte());
            end else begin
               issue_request(CMD_RUN, r, c, 8'($urandom));
               fills++;
            end
         end
         sent += items;
      end
   endtask

   initial begin
      reset            = 1'b1;
      rows_cfg         = CFG_RESET;
      cols_cfg         = CFG_RESET;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_WRITE;
      req_bus.row      <= '0;
      req_bus.col      <= '0;
      req_bus.cell_req <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_ROWS;
      csr_bus.data     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_grid_load();
      test_directed_cases();
      test_result_stall();
      test_random_traffic();

      // wait out the last fill and any trailing writes
      drain_and_settle();
      repeat (48) @(posedge clock);

      $display("Covered %0d cell writes and %0d fills (%0d counts checked) over %0d areas",
               writes_sent, fills_sent, fills_checked, settings_used);
      $display("Included blocked and out-of-area starts, empty and oversized areas, %0d-cycle hold",
               HOLD_CYCLES);
      if (count_errors == 0 && target_counts_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d counts never returned",
                  count_errors, target_counts_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
